// ===== hdl/stfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Subarray target sum finder package
// Shared sizes, status codes, controller states and the result record.
// ----------------------------------------------------------------------------
package stfs_pkg;

  localparam int MaxLen   = 1024;
  localparam int ElemBits = 16;
  localparam int IdxW     = $clog2(MaxLen);
  localparam int PosW     = IdxW + 1;
  localparam int TargetW  = 26;
  localparam int SumW     = TargetW + 1;
  localparam int OutIdxW  = 10;

  typedef enum logic [1:0] {
    STATUS_NONE  = 2'd0,
    STATUS_FOUND = 2'd1,
    STATUS_LONG  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHRINK,
    ST_READ,
    ST_FINAL
  } state_e;

  typedef struct packed {
    status_e              status;
    logic [OutIdxW-1:0]   run_start;
    logic [OutIdxW-1:0]   run_end;
  } result_t;

endpackage

// ===== hdl/stfs_window_engine.sv =====
// ----------------------------------------------------------------------------
// Sliding window engine
// Holds the window elements in a synchronous memory, keeps the running sum
// and drops elements from the window front one memory read at a time.
// ----------------------------------------------------------------------------
module stfs_window_engine
  import stfs_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [stfs_pkg::TargetW-1:0] target_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [15:0]                in_elem_i,
  input  logic                       in_last_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output stfs_pkg::result_t          res_o
);

  state_e              state_q, state_d;
  logic [SumW-1:0]     sum_q, sum_d;
  logic [PosW-1:0]     start_q, start_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [IdxW-1:0]     end_q, end_d;
  logic                match_q, match_d;
  logic                long_q, long_d;
  logic                last_q, last_d;

  logic [ElemBits-1:0] mem [MaxLen];
  logic [ElemBits-1:0] rdata_q;
  logic                mem_we;
  logic [ElemBits-1:0] elem;

  logic                take;
  logic                window_ok;
  logic                shrink_go;
  logic                hit;
  logic                emit;
  logic                done;
  logic [SumW-1:0]     target_ext;

  assign elem       = in_elem_i[ElemBits-1:0];
  assign target_ext = {1'b0, target_i};
  assign in_ready_o = (state_q == ST_IDLE);
  assign take       = in_valid_i && in_ready_o;
  assign window_ok  = (start_q <= {1'b0, end_q});
  assign shrink_go  = (sum_q > target_ext) && window_ok;
  assign hit        = (state_q == ST_SHRINK) && !shrink_go && window_ok &&
                      (sum_q == target_ext);
  assign emit       = hit || (last_q && !match_q);
  assign done       = !emit || res_ready_i;
  assign mem_we     = take && !match_q && !long_q && (pos_q < PosW'(MaxLen));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[pos_q[IdxW-1:0]] <= elem;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[start_q[IdxW-1:0]];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          state_d = mem_we ? ST_SHRINK : ST_FINAL;
        end
      end
      ST_SHRINK: begin
        if (shrink_go) begin
          state_d = ST_READ;
        end else if (done) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        state_d = ST_SHRINK;
      end
      ST_FINAL: begin
        if (done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    sum_d   = sum_q;
    start_d = start_q;
    pos_d   = pos_q;
    end_d   = end_q;
    match_d = match_q;
    long_d  = long_q;
    last_d  = last_q;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          last_d = in_last_i;
          if (mem_we) begin
            sum_d = sum_q + SumW'(elem);
            end_d = pos_q[IdxW-1:0];
            pos_d = pos_q + PosW'(1);
          end else if (!match_q && !long_q) begin
            long_d = 1'b1;
          end
        end
      end
      ST_READ: begin
        sum_d   = sum_q - SumW'(rdata_q);
        start_d = start_q + PosW'(1);
      end
      ST_SHRINK, ST_FINAL: begin
        if (!(state_q == ST_SHRINK && shrink_go) && done) begin
          if (hit) begin
            match_d = 1'b1;
          end
          if (last_q) begin
            sum_d   = '0;
            start_d = '0;
            pos_d   = '0;
            match_d = 1'b0;
            long_d  = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    if ((state_q == ST_SHRINK && !shrink_go) || state_q == ST_FINAL) begin
      res_valid_o = emit;
    end
    if (hit) begin
      res_o.status    = STATUS_FOUND;
      res_o.run_start = OutIdxW'(start_q);
      res_o.run_end   = OutIdxW'(end_q);
    end else if (long_q) begin
      res_o.status = STATUS_LONG;
    end else begin
      res_o.status = STATUS_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sum_q   <= '0;
      start_q <= '0;
      pos_q   <= '0;
      end_q   <= '0;
      match_q <= 1'b0;
      long_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      end_q   <= end_d;
      match_q <= match_d;
      long_q  <= long_d;
      last_q  <= last_d;
    end
  end

  a_pos_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(MaxLen))
    else $error("position beyond the store depth");

  a_start_le_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q <= pos_q)
    else $error("window start passed the position");

  a_read_after_shrink : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> $past(state_q) == ST_SHRINK)
    else $error("store read without a shrink decision");

  a_hit_not_repeated : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |-> !match_q)
    else $error("second match reported for one array");

endmodule

// ===== hdl/stfs_result_buf.sv =====
// ----------------------------------------------------------------------------
// Result output register
// Holds one result transaction so the engine can move on while it waits.
// ----------------------------------------------------------------------------
module stfs_result_buf
  import stfs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  output logic              res_ready_o,
  input  stfs_pkg::result_t res_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output stfs_pkg::result_t out_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign res_ready_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (res_valid_i && res_ready_o) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      data_q <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

endmodule

// ===== hdl/subarray_target_sum_finder_unit.sv =====
// ----------------------------------------------------------------------------
// Subarray target sum finder
// Finds the first contiguous run of a stream whose sum equals a target.
// ----------------------------------------------------------------------------
// Elements of one array arrive on the slave stream, the final one marked by
// tlast. The block reports the first contiguous run that sums to the target
// register as one result transaction (status found, start and end indices);
// otherwise the final element yields status not found, or array too long when
// more than 1024 elements arrived. An element that is stored passes through the
// idle and shrink states, plus a read state and a return to shrink for each
// element dropped from the window front, one read of the window memory and one
// subtraction each; each element is dropped at most once. Elements that are
// not stored pass through the idle and final states. One result waits in an
// output register without holding up the input; a further result stalls the
// input until the waiting one has been taken.
module subarray_target_sum_finder_unit
  import stfs_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [stfs_pkg::TargetW-1:0] cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [15:0]                  s_axis_tdata,   // element_value
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [23:0]                  m_axis_tdata    // status, run_start, run_end
);

  logic [TargetW-1:0] target_q;
  logic               res_valid;
  logic               res_ready;
  result_t            res;
  result_t            out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  stfs_window_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .target_i    (target_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_elem_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  stfs_result_buf u_result_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out)
  );

  assign m_axis_tdata = {2'b00, out.run_end, out.run_start, out.status};

endmodule
